FILE: hw/rtl/two_level_page_table_mapper_defines.svh
// Assertion macros for the two-level page table mapper.
// No dependencies; included by the top level only.
`ifndef TWO_LEVEL_PAGE_TABLE_MAPPER_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_MAPPER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TLPTM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TLPTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tlptm_pkg.sv
// Shared types and constants of the two-level page table mapper.
// No dependencies.
package tlptm_pkg;

    localparam int VA_W    = 32;
    localparam int LEN_W   = 32;
    localparam int PA_W    = 32;
    localparam int PERM_W  = 12;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 32;
    localparam int PAGES_W = 21;
    localparam int FRAME_W = 20;
    localparam int VPN_W   = 20;
    localparam int SLOT_W  = 10;

    localparam logic CMD_MAP    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_POOL_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_TABLE   = 2'd2;

    localparam logic [ENTRY_W-1:0] FLAG_PRESENT = 32'h0000_0001;
    // present | write | user for a freshly allocated directory slot
    localparam logic [11:0]        DIR_FLAGS    = 12'h007;

    typedef struct packed {
        logic               command;
        logic [VA_W-1:0]    virt_addr;
        logic [LEN_W-1:0]   length;
        logic [PA_W-1:0]    phys_addr;
        logic [PERM_W-1:0]  perm;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ENTRY_W-1:0] entry;
        logic [PAGES_W-1:0] pages_mapped;
    } t_result;

endpackage

FILE: hw/rtl/tlptm_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module tlptm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                            i_wdata,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tlptm_walker.sv
// Walk sequencer: clearing sweep, directory read/modify/write, page entry access.
// Depends on tlptm_pkg; drives the two tlptm_ram instances in the top level.
module tlptm_walker #(
    parameter int TABLE_COUNT = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_valid,
    input  tlptm_pkg::t_item         i_item,
    output logic                     o_item_ready,
    input  logic [tlptm_pkg::FRAME_W-1:0] i_pool_frame,
    output logic                     o_done,
    output tlptm_pkg::t_result       o_result,
    input  logic                     i_take,
    output logic [tlptm_pkg::SLOT_W-1:0] o_dir_addr,
    output logic                     o_dir_we,
    output logic [32+((TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1)-1:0] o_dir_wdata,
    input  logic [32+((TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1)-1:0] i_dir_rdata,
    output logic [((TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1)+tlptm_pkg::SLOT_W-1:0] o_pg_addr,
    output logic                     o_pg_we,
    output logic [tlptm_pkg::ENTRY_W-1:0] o_pg_wdata,
    input  logic [tlptm_pkg::ENTRY_W-1:0] i_pg_rdata
);

    localparam int IDX_W    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int NF_W     = $clog2(TABLE_COUNT + 1);
    localparam int PGA_W    = IDX_W + tlptm_pkg::SLOT_W;
    localparam int PG_DEPTH = TABLE_COUNT * 1024;
    localparam int VPN_W    = tlptm_pkg::VPN_W;
    localparam int SLOT_W   = tlptm_pkg::SLOT_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SETUP, S_DIR_RD, S_DIR_CHK, S_PG_RD, S_DONE
    } t_state;

    t_state                           r_state, n_state;
    logic                             r_cmd, n_cmd;
    logic [VPN_W-1:0]                 r_vpn, n_vpn;
    logic [VPN_W-1:0]                 r_last_vpn, n_last_vpn;
    logic [tlptm_pkg::PA_W-1:0]       r_pa, n_pa;
    logic [tlptm_pkg::PERM_W-1:0]     r_perm, n_perm;
    logic [tlptm_pkg::PAGES_W-1:0]    r_left, n_left;
    logic [tlptm_pkg::PAGES_W-1:0]    r_mapped, n_mapped;
    logic [tlptm_pkg::STAT_W-1:0]     r_status, n_status;
    logic [tlptm_pkg::ENTRY_W-1:0]    r_entry, n_entry;
    logic [NF_W-1:0]                  r_next_free, n_next_free;
    logic [PGA_W-1:0]                 r_clr_cnt, n_clr_cnt;

    logic                             dir_present;
    logic [IDX_W-1:0]                 tbl_idx;
    logic [tlptm_pkg::FRAME_W-1:0]    new_frame;
    logic [tlptm_pkg::VA_W-1:0]       end_addr;
    logic                             pool_empty;

    assign dir_present = i_dir_rdata[0];
    assign tbl_idx     = dir_present ? i_dir_rdata[32 +: IDX_W] : r_next_free[IDX_W-1:0];
    assign new_frame   = i_pool_frame + tlptm_pkg::FRAME_W'(r_next_free);
    assign end_addr    = i_item.virt_addr + i_item.length - 32'd1;
    assign pool_empty  = (r_next_free == NF_W'(TABLE_COUNT));

    // next-state and datapath
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_vpn       = r_vpn;
        n_last_vpn  = r_last_vpn;
        n_pa        = r_pa;
        n_perm      = r_perm;
        n_left      = r_left;
        n_mapped    = r_mapped;
        n_status    = r_status;
        n_entry     = r_entry;
        n_next_free = r_next_free;
        n_clr_cnt   = r_clr_cnt;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + PGA_W'(1);
                if (r_clr_cnt == PGA_W'(PG_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item_valid) begin
                    n_cmd      = i_item.command;
                    n_vpn      = i_item.virt_addr[31:12];
                    n_last_vpn = end_addr[31:12];
                    n_pa       = i_item.phys_addr;
                    n_perm     = i_item.perm;
                    n_mapped   = '0;
                    n_status   = tlptm_pkg::ST_OK;
                    n_entry    = '0;
                    if (i_item.command == tlptm_pkg::CMD_LOOKUP) begin
                        n_state = S_DIR_RD;
                    end else if (i_item.length == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_left  = {1'b0, r_last_vpn - r_vpn} + tlptm_pkg::PAGES_W'(1);
                n_state = S_DIR_RD;
            end
            S_DIR_RD: begin
                n_state = S_DIR_CHK;
            end
            S_DIR_CHK: begin
                if (r_cmd == tlptm_pkg::CMD_LOOKUP) begin
                    if (!dir_present) begin
                        n_status = tlptm_pkg::ST_NO_TABLE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_PG_RD;
                    end
                end else if (!dir_present && pool_empty) begin
                    n_status = tlptm_pkg::ST_POOL_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    if (!dir_present) begin
                        n_next_free = r_next_free + NF_W'(1);
                    end
                    n_mapped = r_mapped + tlptm_pkg::PAGES_W'(1);
                    n_left   = r_left - tlptm_pkg::PAGES_W'(1);
                    n_vpn    = r_vpn + VPN_W'(1);
                    n_pa     = r_pa + 32'h0000_1000;
                    n_state  = (r_left == tlptm_pkg::PAGES_W'(1)) ? S_DONE : S_DIR_RD;
                end
            end
            S_PG_RD: begin
                n_entry = i_pg_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_next_free <= '0;
            r_clr_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_clr_cnt   <= n_clr_cnt;
        end
        r_cmd      <= n_cmd;
        r_vpn      <= n_vpn;
        r_last_vpn <= n_last_vpn;
        r_pa       <= n_pa;
        r_perm     <= n_perm;
        r_left     <= n_left;
        r_mapped   <= n_mapped;
        r_status   <= n_status;
        r_entry    <= n_entry;
    end

    // memory ports
    always_comb begin
        o_dir_addr  = r_vpn[VPN_W-1:SLOT_W];
        o_dir_we    = 1'b0;
        o_dir_wdata = {tbl_idx, new_frame, tlptm_pkg::DIR_FLAGS};
        o_pg_addr   = {tbl_idx, r_vpn[SLOT_W-1:0]};
        o_pg_we     = 1'b0;
        o_pg_wdata  = r_pa | {20'd0, r_perm} | tlptm_pkg::FLAG_PRESENT;
        if (r_state == S_CLEAR) begin
            o_dir_addr  = r_clr_cnt[SLOT_W-1:0];
            o_dir_we    = 1'b1;
            o_dir_wdata = '0;
            o_pg_addr   = r_clr_cnt;
            o_pg_we     = 1'b1;
            o_pg_wdata  = '0;
        end else if (r_state == S_DIR_CHK && r_cmd == tlptm_pkg::CMD_MAP
                     && (dir_present || !pool_empty)) begin
            o_dir_we = !dir_present;
            o_pg_we  = 1'b1;
        end
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_done       = (r_state == S_DONE);

    always_comb begin
        o_result.status       = r_status;
        o_result.entry        = r_entry;
        o_result.pages_mapped = r_mapped;
    end

endmodule

FILE: hw/rtl/two_level_page_table_mapper.sv
// Top level of the two-level page table mapper: ports, pool frame register,
// result register, directory and page entry memories.
// Depends on tlptm_pkg, tlptm_ram, tlptm_walker and the defines header.
//
// Usage
//   In (i_in_valid / o_in_stall): one command item, map a range of 4 KiB
//   pages or look up the entry of one address. Out (o_out_valid /
//   i_out_stall): one result item per command. Config (i_cfg_valid /
//   o_cfg_ready): 20-bit frame of pool table 0; write only while idle.
// Operation
//   One item at a time. A lookup reads the directory, checks it and, with a
//   table present, reads the page entry. A map takes, per page, a directory
//   read, then a check plus page write (single-port memories); a zero-length
//   map does neither. The next item is taken the cycle after the result moves out.
// Reset
//   Synchronous, active low. A clearing sweep then zeroes both memories;
//   o_in_stall stays high meanwhile.
// Stall
//   The result waits in an output register and the next item is taken
//   meanwhile; a second result waits in the walker until the register frees.
`include "two_level_page_table_mapper_defines.svh"

module two_level_page_table_mapper #(
    parameter int TABLE_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_length,
    input  logic [31:0] i_phys_addr,
    input  logic [11:0] i_perm,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_entry,
    output logic [20:0] o_pages_mapped,
    // pool frame register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_table_pool_frame
);

    localparam int IDX_W    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int DIR_W    = 32 + IDX_W;       // {pool index, directory entry}
    localparam int PGA_W    = IDX_W + tlptm_pkg::SLOT_W;
    localparam int PG_DEPTH = TABLE_COUNT * 1024;
    localparam int PG_AW    = $clog2(PG_DEPTH);

    tlptm_pkg::t_item   item;
    tlptm_pkg::t_result w_result;
    logic               w_ready;
    logic               w_done;
    logic               w_take;

    logic [tlptm_pkg::FRAME_W-1:0] r_pool_frame;
    logic                          r_cfg_ready;

    logic                          r_out_valid;
    tlptm_pkg::t_result            r_result;

    logic [tlptm_pkg::SLOT_W-1:0]  dir_addr;
    logic                          dir_we;
    logic [DIR_W-1:0]              dir_wdata;
    logic [DIR_W-1:0]              dir_rdata;
    logic [PGA_W-1:0]              pg_addr;
    logic                          pg_we;
    logic [31:0]                   pg_wdata;
    logic [31:0]                   pg_rdata;

    always_comb begin
        item.command   = i_command;
        item.virt_addr = i_virt_addr;
        item.length    = i_length;
        item.phys_addr = i_phys_addr;
        item.perm      = i_perm;
    end

    // pool frame register; ready drops only during reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_frame <= '0;
            r_cfg_ready  <= 1'b0;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                r_pool_frame <= i_table_pool_frame;
            end
        end
    end

    tlptm_walker #(
        .TABLE_COUNT (TABLE_COUNT)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in_valid),
        .i_item       (item),
        .o_item_ready (w_ready),
        .i_pool_frame (r_pool_frame),
        .o_done       (w_done),
        .o_result     (w_result),
        .i_take       (w_take),
        .o_dir_addr   (dir_addr),
        .o_dir_we     (dir_we),
        .o_dir_wdata  (dir_wdata),
        .i_dir_rdata  (dir_rdata),
        .o_pg_addr    (pg_addr),
        .o_pg_we      (pg_we),
        .o_pg_wdata   (pg_wdata),
        .i_pg_rdata   (pg_rdata)
    );

    // directory: entry plus the pool index of its table
    tlptm_ram #(
        .WIDTH (DIR_W),
        .DEPTH (1024)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_addr  (dir_addr),
        .i_wdata (dir_wdata),
        .o_rdata (dir_rdata)
    );

    // second-level tables, TABLE_COUNT x 1024 entries
    tlptm_ram #(
        .WIDTH (32),
        .DEPTH (PG_DEPTH)
    ) u_pg_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_addr  (pg_addr[PG_AW-1:0]),
        .i_wdata (pg_wdata),
        .o_rdata (pg_rdata)
    );

    // result register: loads when empty or being drained this cycle
    assign w_take = w_done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_result <= w_result;
        end
    end

    assign o_in_stall     = !w_ready;
    assign o_cfg_ready    = r_cfg_ready;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_result.status;
    assign o_entry        = r_result.entry;
    assign o_pages_mapped = r_result.pages_mapped;

    // a lookup miss carries no entry and no page count
    `TLPTM_ASSERT_NOW(a_no_table_clean, i_clk, i_rst_n,
        o_out_valid && o_status == tlptm_pkg::ST_NO_TABLE,
        o_entry == '0 && o_pages_mapped == '0, "no_table result carries data")
    // a pool-exhausted map never reports an entry
    `TLPTM_ASSERT_NOW(a_pool_empty_clean, i_clk, i_rst_n,
        o_out_valid && o_status == tlptm_pkg::ST_POOL_EMPTY,
        o_entry == '0, "pool_empty result carries an entry")
    // an accepted item makes the block busy in the next cycle
    `TLPTM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, o_in_stall, "block still idle after accept")
    // a finished result handed over is visible in the next cycle
    `TLPTM_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n,
        w_take, o_out_valid, "taken result not presented")

endmodule
